// ===== sv/tdor_pkg.sv =====
// Package for the torus dimension-order route block: item types, control word
// layout, condition codes and the microprogram table used by the sequencer.
// No dependencies.
package tdor_pkg;

   // Field widths of the items and the grid registers.
   localparam int NODE_W = 10;
   localparam int SIDE_W = 6;
   localparam int HOP_W  = 6;
   localparam int COORD_W = 5;
   localparam int DELTA_W = 7;
   localparam int TOTAL_W = 11;
   localparam int PC_W   = 4;

   // Configuration register indexes.
   localparam logic REG_GRID_ROWS = 1'b0;
   localparam logic REG_GRID_COLS = 1'b1;

   // Microprogram addresses.
   localparam logic [PC_W-1:0] PC_CHECK  = 4'd0;
   localparam logic [PC_W-1:0] PC_SOURCE = 4'd1;
   localparam logic [PC_W-1:0] PC_DIV    = 4'd2;
   localparam logic [PC_W-1:0] PC_DELTA  = 4'd3;
   localparam logic [PC_W-1:0] PC_X_TEST = 4'd4;
   localparam logic [PC_W-1:0] PC_X_LOOP = 4'd5;
   localparam logic [PC_W-1:0] PC_Y_TEST = 4'd6;
   localparam logic [PC_W-1:0] PC_Y_LOOP = 4'd7;
   localparam logic [PC_W-1:0] PC_END    = 4'd8;
   localparam logic [PC_W-1:0] PC_ERR    = 4'd9;

   typedef struct packed {
      logic [NODE_W-1:0] src_node;
      logic [NODE_W-1:0] dst_node;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [HOP_W-1:0]  hop_index;
      logic              last;
      logic              error;
   } rsp_type;

   // Datapath operations selected by the control word.
   typedef enum logic [2:0] {
      OP_NONE     = 3'd0,
      OP_EMIT_SRC = 3'd1,
      OP_DIV      = 3'd2,
      OP_DELTA    = 3'd3,
      OP_STEP_X   = 3'd4,
      OP_STEP_Y   = 3'd5,
      OP_ERR      = 3'd6
   } op_type;

   // Jump conditions tested by the sequencer.
   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_BAD      = 3'd1,
      COND_SAME     = 3'd2,
      COND_DIV_MORE = 3'd3,
      COND_DX_ZERO  = 3'd4,
      COND_DX_MORE  = 3'd5,
      COND_DY_ZERO  = 3'd6,
      COND_DY_MORE  = 3'd7
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [PC_W-1:0]   target;
      logic              done;
   } ctrl_type;

   // Status flags from the datapath that the jump conditions look at.
   typedef struct packed {
      logic bad;
      logic same;
      logic div_more;
      logic dx_zero;
      logic dx_more;
      logic dy_zero;
      logic dy_more;
   } flags_type;

   localparam ctrl_type CTRL_IDLE = '{op: OP_NONE, cond: COND_NEVER, target: PC_END, done: 1'b0};

   // The route program: one control word per step.
   function automatic ctrl_type step_rom(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = CTRL_IDLE;
      case (pc)
         PC_CHECK:  w = '{op: OP_NONE,     cond: COND_BAD,      target: PC_ERR,    done: 1'b0};
         PC_SOURCE: w = '{op: OP_EMIT_SRC, cond: COND_SAME,     target: PC_END,    done: 1'b0};
         PC_DIV:    w = '{op: OP_DIV,      cond: COND_DIV_MORE, target: PC_DIV,    done: 1'b0};
         PC_DELTA:  w = '{op: OP_DELTA,    cond: COND_NEVER,    target: PC_END,    done: 1'b0};
         PC_X_TEST: w = '{op: OP_NONE,     cond: COND_DX_ZERO,  target: PC_Y_TEST, done: 1'b0};
         PC_X_LOOP: w = '{op: OP_STEP_X,   cond: COND_DX_MORE,  target: PC_X_LOOP, done: 1'b0};
         PC_Y_TEST: w = '{op: OP_NONE,     cond: COND_DY_ZERO,  target: PC_END,    done: 1'b0};
         PC_Y_LOOP: w = '{op: OP_STEP_Y,   cond: COND_DY_MORE,  target: PC_Y_LOOP, done: 1'b0};
         PC_END:    w = '{op: OP_NONE,     cond: COND_NEVER,    target: PC_END,    done: 1'b1};
         PC_ERR:    w = '{op: OP_ERR,      cond: COND_NEVER,    target: PC_END,    done: 1'b1};
         default:   w = '{op: OP_NONE,     cond: COND_NEVER,    target: PC_END,    done: 1'b1};
      endcase
      return w;
   endfunction

endpackage

// ===== sv/tdor_seq.sv =====
// Microcode sequencer for the torus route block: step counter, program table
// lookup and conditional jumps. Depends on tdor_pkg.
module tdor_seq
   import tdor_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  flags_type flags,
   output logic      busy,
   output ctrl_type  ctrl
);

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff, busy_in;
   ctrl_type        word;
   logic            take;

   // Fetch the control word of the current step; nothing runs while idle.
   always_comb begin
      word = step_rom(pc_ff);
      ctrl = busy_ff ? word : CTRL_IDLE;
   end

   // Evaluate the jump condition of the current word.
   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:    take = 1'b0;
         COND_BAD:      take = flags.bad;
         COND_SAME:     take = flags.same;
         COND_DIV_MORE: take = flags.div_more;
         COND_DX_ZERO:  take = flags.dx_zero;
         COND_DX_MORE:  take = flags.dx_more;
         COND_DY_ZERO:  take = flags.dy_zero;
         COND_DY_MORE:  take = flags.dy_more;
         default:       take = 1'b0;
      endcase
   end

   // Next step: start the program on a new item, stop on a done word.
   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = PC_CHECK;
         end
      end else if (ctrl.done) begin
         busy_in = 1'b0;
      end else if (take) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_CHECK;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ===== sv/torus_dimension_order_route.sv =====
// Dimension-order route on a 2D torus: emits the node list from source to destination,
// x hops first, then y hops, the shorter way around each ring. Depends on tdor_pkg, tdor_seq.
// Steps: CHECK, then ERR (one error item for off-grid nodes) or SOURCE (the source node,
// the end for equal nodes), then the division, one quotient bit per cycle, DELTA and the
// walk, one route node per cycle. No item is taken while busy. No result stalls.
// Reset is synchronous and active high; it sets the grid to 4 by 4 and idles the block.
module torus_dimension_order_route
   import tdor_pkg::*;
#(
   parameter int MAX_SIDE = 32
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   output logic              rsp_valid,
   output rsp_type           rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [SIDE_W-1:0] csr_wdata
);

   localparam int DIV_STEPS = NODE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Side clamp: zero acts as one, anything above the maximum as the maximum.
   function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      r = v;
      if (v == '0)
         r = SIDE_W'(1);
      else if (v > SIDE_W'(MAX_SIDE))
         r = SIDE_W'(MAX_SIDE);
      return r;
   endfunction

   // Shortest signed offset from a to b on a ring of the given length.
   function automatic logic signed [DELTA_W-1:0] ring_delta(
      input logic [COORD_W-1:0] a,
      input logic [COORD_W-1:0] b,
      input logic [SIDE_W-1:0]  len
   );
      logic signed [DELTA_W-1:0] d, half, len_s;
      d     = signed'({2'b00, b}) - signed'({2'b00, a});
      half  = signed'({2'b00, len[SIDE_W-1:1]});
      len_s = signed'({1'b0, len});
      if (d > half)
         d = d - len_s;
      else if (d < -half)
         d = d + len_s;
      return d;
   endfunction

   ctrl_type  ctrl;
   flags_type flags;
   logic      accept;

   logic [SIDE_W-1:0]  grid_rows_ff, grid_cols_ff;
   logic [SIDE_W-1:0]  rows_ff, cols_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [NODE_W-1:0]  src_ff, dst_ff;
   logic [NODE_W-1:0]  src_num_ff, dst_num_ff, src_num_in, dst_num_in;
   logic [COORD_W-1:0] src_rem_ff, dst_rem_ff, src_rem_in, dst_rem_in;
   logic [CNT_W-1:0]   div_cnt_ff;
   logic [COORD_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [DELTA_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [HOP_W-1:0]   hop_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff, rsp_item_in;
   logic [SIDE_W-1:0]  src_trial, dst_trial;
   logic               src_ge, dst_ge;
   logic [TOTAL_W-1:0] node_wide;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   tdor_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   // Grid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= SIDE_W'(4);
         grid_cols_ff <= SIDE_W'(4);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GRID_ROWS: grid_rows_ff <= csr_wdata;
            REG_GRID_COLS: grid_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Status flags for the jump conditions.
   always_comb begin
      flags.bad      = ({1'b0, src_ff} >= total_ff) || ({1'b0, dst_ff} >= total_ff);
      flags.same     = (src_ff == dst_ff);
      flags.div_more = (div_cnt_ff != '0);
      flags.dx_zero  = (dx_ff == '0);
      flags.dx_more  = (dx_ff != DELTA_W'(1)) && (dx_ff != -DELTA_W'(1));
      flags.dy_zero  = (dy_ff == '0);
      flags.dy_more  = (dy_ff != DELTA_W'(1)) && (dy_ff != -DELTA_W'(1));
   end

   // One restoring division step on both nodes by the column count.
   always_comb begin
      src_trial  = {src_rem_ff, src_num_ff[NODE_W-1]};
      dst_trial  = {dst_rem_ff, dst_num_ff[NODE_W-1]};
      src_ge     = (src_trial >= cols_ff);
      dst_ge     = (dst_trial >= cols_ff);
      src_rem_in = src_ge ? COORD_W'(src_trial - cols_ff) : src_trial[COORD_W-1:0];
      dst_rem_in = dst_ge ? COORD_W'(dst_trial - cols_ff) : dst_trial[COORD_W-1:0];
      src_num_in = {src_num_ff[NODE_W-2:0], src_ge};
      dst_num_in = {dst_num_ff[NODE_W-2:0], dst_ge};
   end

   // Route walk: set up coordinates and offsets, then move one hop in x or y and keep the node number in step.
   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      node_wide = {1'b0, node_ff};
      unique case (ctrl.op)
         OP_DELTA: begin
            x_in      = src_rem_ff;
            y_in      = src_num_ff[COORD_W-1:0];
            dx_in     = ring_delta(src_rem_ff, dst_rem_ff, cols_ff);
            dy_in     = ring_delta(src_num_ff[COORD_W-1:0], dst_num_ff[COORD_W-1:0], rows_ff);
         end
         OP_STEP_X: begin
            if (!dx_ff[DELTA_W-1]) begin
               dx_in = dx_ff - DELTA_W'(1);
               if ({1'b0, x_ff} == cols_ff - SIDE_W'(1)) begin
                  x_in      = '0;
                  node_wide = {1'b0, node_ff} - TOTAL_W'(cols_ff) + TOTAL_W'(1);
               end else begin
                  x_in      = x_ff + COORD_W'(1);
                  node_wide = {1'b0, node_ff} + TOTAL_W'(1);
               end
            end else begin
               dx_in = dx_ff + DELTA_W'(1);
               if (x_ff == '0) begin
                  x_in      = COORD_W'(cols_ff - SIDE_W'(1));
                  node_wide = {1'b0, node_ff} + TOTAL_W'(cols_ff) - TOTAL_W'(1);
               end else begin
                  x_in      = x_ff - COORD_W'(1);
                  node_wide = {1'b0, node_ff} - TOTAL_W'(1);
               end
            end
         end
         OP_STEP_Y: begin
            if (!dy_ff[DELTA_W-1]) begin
               dy_in = dy_ff - DELTA_W'(1);
               if ({1'b0, y_ff} == rows_ff - SIDE_W'(1)) begin
                  y_in      = '0;
                  node_wide = TOTAL_W'(x_ff);
               end else begin
                  y_in      = y_ff + COORD_W'(1);
                  node_wide = {1'b0, node_ff} + TOTAL_W'(cols_ff);
               end
            end else begin
               dy_in = dy_ff + DELTA_W'(1);
               if (y_ff == '0) begin
                  y_in      = COORD_W'(rows_ff - SIDE_W'(1));
                  node_wide = total_ff - TOTAL_W'(cols_ff) + TOTAL_W'(x_ff);
               end else begin
                  y_in      = y_ff - COORD_W'(1);
                  node_wide = {1'b0, node_ff} - TOTAL_W'(cols_ff);
               end
            end
         end
         default: ;
      endcase
      node_in = node_wide[NODE_W-1:0];
   end

   // Result register: one strobe per emitted route node or error item.
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      unique case (ctrl.op)
         OP_EMIT_SRC: begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = '{node: src_ff, hop_index: '0, last: flags.same, error: 1'b0};
         end
         OP_STEP_X: begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = '{node: node_in, hop_index: hop_ff + HOP_W'(1),
                             last: !flags.dx_more && flags.dy_zero, error: 1'b0};
         end
         OP_STEP_Y: begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = '{node: node_in, hop_index: hop_ff + HOP_W'(1),
                             last: !flags.dy_more, error: 1'b0};
         end
         OP_ERR: begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = '{node: '0, hop_index: '0, last: 1'b1, error: 1'b1};
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept)
            div_cnt_ff <= CNT_W'(DIV_STEPS - 1);
         else if (ctrl.op == OP_DIV)
            div_cnt_ff <= div_cnt_ff - CNT_W'(1);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      if (accept) begin
         src_ff     <= req_item.src_node;
         dst_ff     <= req_item.dst_node;
         src_num_ff <= req_item.src_node;
         dst_num_ff <= req_item.dst_node;
         src_rem_ff <= '0;
         dst_rem_ff <= '0;
         rows_ff    <= eff_side(grid_rows_ff);
         cols_ff    <= eff_side(grid_cols_ff);
         total_ff   <= TOTAL_W'(eff_side(grid_rows_ff) * eff_side(grid_cols_ff));
         node_ff    <= req_item.src_node;
         hop_ff     <= '0;
      end else begin
         if (ctrl.op == OP_DIV) begin
            src_num_ff <= src_num_in;
            dst_num_ff <= dst_num_in;
            src_rem_ff <= src_rem_in;
            dst_rem_ff <= dst_rem_in;
         end
         if (ctrl.op == OP_STEP_X || ctrl.op == OP_STEP_Y) begin
            node_ff <= node_in;
            hop_ff  <= hop_ff + HOP_W'(1);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for torus_dimension_order_route: random and directed
// routes on several grid shapes, each result checked against a route predictor.
// Depends on tdor_pkg and the torus_dimension_order_route RTL.
`timescale 1ns / 100ps

module testbench;
   import tdor_pkg::*;

   localparam int MAX_SIDE = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 10;
   localparam int ITEMS_PER_PHASE = 35;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   req_type           req_item = '0;
   logic              rsp_valid;
   rsp_type           rsp_item;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = REG_GRID_ROWS;
   logic [SIDE_W-1:0] csr_wdata = '0;

   // Grid shape as the block should see it, updated on each register write.
   logic [SIDE_W-1:0] rows_cfg = 6'd4;
   logic [SIDE_W-1:0] cols_cfg = 6'd4;

   // Items waiting to be sent and route nodes waiting to come back.
   req_type request_q [$];
   rsp_type route_q [$];

   int fail_count = 0;
   int cycle_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   logic    next_start;
   req_type next_item;
   rsp_type want_node;

   // Grid shapes of the random phases; zero and values above the limit included.
   int phase_rows [PHASE_COUNT] = '{32, 5, 1, 32, 3, 16, 63, 0, 8, 2};
   int phase_cols [PHASE_COUNT] = '{32, 7, 32, 1, 31, 2, 40, 9, 8, 0};

   torus_dimension_order_route #(.MAX_SIDE(MAX_SIDE)) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A side register of zero acts as one, and one above the limit as the limit.
   function automatic int side_of(input logic [SIDE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return int'(v);
   endfunction

   // Shortest signed offset around a ring; a tie on an even ring keeps its sign.
   function automatic int ring_offset(input int from_pos, input int to_pos, input int len);
      int d;
      int half;
      d = to_pos - from_pos;
      half = len / 2;
      if (d > half) d -= len;
      else if (d < -half) d += len;
      return d;
   endfunction

   function automatic void push_node(input int node, input int hop, input bit last,
                                     input bit err);
      rsp_type r;
      r.node = node[NODE_W-1:0];
      r.hop_index = hop[HOP_W-1:0];
      r.last = last;
      r.error = err;
      route_q.insert(route_q.size(), r);
   endfunction

   // Works out the node list of one route: source, x hops, then y hops; an error item if off the grid.
   function automatic void predict_route(input req_type item);
      int rows;
      int cols;
      int src;
      int dst;
      int x;
      int y;
      int dx;
      int dy;
      int hops;
      int n;
      rows = side_of(rows_cfg);
      cols = side_of(cols_cfg);
      src = int'(item.src_node);
      dst = int'(item.dst_node);
      if (src >= rows * cols || dst >= rows * cols) begin
         push_node(0, 0, 1'b1, 1'b1);
         return;
      end
      if (src == dst) begin
         push_node(src, 0, 1'b1, 1'b0);
         return;
      end
      x = src % cols;
      y = src / cols;
      dx = ring_offset(x, dst % cols, cols);
      dy = ring_offset(y, dst / cols, rows);
      hops = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
      n = 0;
      push_node(src, n, hops == 0, 1'b0);
      while (dx != 0) begin
         if (dx > 0) begin
            x = (x + 1 == cols) ? 0 : x + 1;
            dx--;
         end else begin
            x = (x == 0) ? cols - 1 : x - 1;
            dx++;
         end
         n++;
         push_node(y * cols + x, n, n == hops, 1'b0);
      end
      while (dy != 0) begin
         if (dy > 0) begin
            y = (y + 1 == rows) ? 0 : y + 1;
            dy--;
         end else begin
            y = (y == 0) ? rows - 1 : y - 1;
            dy++;
         end
         n++;
         push_node(y * cols + x, n, n == hops, 1'b0);
      end
   endfunction

   // Sender: bursts of random length with random gaps, fed from the request queue.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         next_item = req_item;
         if (start && !busy) begin
            predict_route(req_item);
            next_start = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_q.size() > 0) begin
               next_start = 1'b1;
               next_item = request_q.pop_front();
            end
         end
         start <= next_start;
         req_item <= next_item;
      end
   end

   // Result checker: each route node against the oldest predicted one.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (route_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected route node %0d hop %0d last %0b error %0b",
                        $realtime, rsp_item.node, rsp_item.hop_index, rsp_item.last,
                        rsp_item.error);
         end else begin
            want_node = route_q.pop_front();
            if (rsp_item.node !== want_node.node ||
                rsp_item.hop_index !== want_node.hop_index ||
                rsp_item.last !== want_node.last ||
                rsp_item.error !== want_node.error) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: route node mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                           $realtime, want_node.node, want_node.hop_index, want_node.last,
                           want_node.error, rsp_item.node, rsp_item.hop_index,
                           rsp_item.last, rsp_item.error);
            end
         end
      end
   end

   // Watchdog against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[torus_dimension_order_route] ERROR");
         $finish;
      end
   end

   task automatic write_grid(input logic idx, input logic [SIDE_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_GRID_ROWS) rows_cfg = val;
      else cols_cfg = val;
   endtask

   // Waits until every item is sent, every route node has come back and the block is idle.
   task automatic drain_routes();
      while (request_q.size() != 0 || start || route_q.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic add_route(input int src, input int dst);
      req_type item;
      item.src_node = src[NODE_W-1:0];
      item.dst_node = dst[NODE_W-1:0];
      request_q.insert(request_q.size(), item);
   endtask

   // Mostly routes inside the grid, some equal nodes and some anywhere in range.
   task automatic add_random_routes(input int count);
      int total;
      int pick;
      int node;
      total = side_of(rows_cfg) * side_of(cols_cfg);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            add_route($urandom_range(0, 1023), $urandom_range(0, 1023));
         end else if (pick == 1) begin
            node = $urandom_range(0, total - 1);
            add_route(node, node);
         end else begin
            add_route($urandom_range(0, total - 1), $urandom_range(0, total - 1));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset grid of 4 by 4: ties, wraps, equal nodes and nodes off the grid.
      add_route(0, 0);
      add_route(0, 15);
      add_route(0, 2);
      add_route(2, 0);
      add_route(0, 10);
      add_route(15, 0);
      add_route(16, 0);
      add_route(0, 16);
      add_route(1023, 1023);
      drain_routes();

      // Largest grid: the longest route and all-ones node numbers.
      write_grid(REG_GRID_ROWS, 6'd32);
      write_grid(REG_GRID_COLS, 6'd32);
      add_route(0, 528);
      add_route(528, 0);
      add_route(0, 1023);
      add_route(1023, 0);
      add_route(1023, 1023);
      add_route(682, 341);
      drain_routes();

      // Zero sides act as a single node.
      write_grid(REG_GRID_ROWS, 6'd0);
      write_grid(REG_GRID_COLS, 6'd0);
      add_route(0, 0);
      add_route(0, 1);
      add_route(1, 0);
      drain_routes();

      // One row of three: odd ring in x only.
      write_grid(REG_GRID_ROWS, 6'd1);
      write_grid(REG_GRID_COLS, 6'd3);
      add_route(0, 1);
      add_route(0, 2);
      add_route(2, 0);
      drain_routes();

      // Random phases over a range of grid shapes.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_grid(REG_GRID_ROWS, phase_rows[p][SIDE_W-1:0]);
         write_grid(REG_GRID_COLS, phase_cols[p][SIDE_W-1:0]);
         add_random_routes(ITEMS_PER_PHASE);
         drain_routes();
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("[torus_dimension_order_route] OK");
      else
         $display("[torus_dimension_order_route] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
sv/tdor_pkg.sv
sv/tdor_seq.sv
sv/torus_dimension_order_route.sv
verif/testbench.sv
